FILE: hw/rtl/fqgc_pkg.sv
// Shared types and constants for the FASTQ quality and GC statistics block.
package fqgc_pkg;

    localparam int PCT_W    = 14;
    localparam int OUT_W    = 40;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;

    // result beat layout, lowest bit first
    localparam int LQ_LSB   = 0;
    localparam int HQ_LSB   = LQ_LSB + PCT_W;
    localparam int GC_LSB   = HQ_LSB + PCT_W;
    localparam int MEAN_LSB = GC_LSB + PCT_W;
    localparam int TOT_LSB  = MEAN_LSB + OUT_W;
    localparam int M_DATA_BITS = TOT_LSB + OUT_W;
    localparam int M_DATA_W = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_USER_W = 2;
    localparam int EMPTY_BIT = 0;
    localparam int SAT_BIT   = 1;

    localparam logic [BYTE_W-1:0] CHAR_NL = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_G  = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_C  = 8'h43;

    localparam logic [CFG_IDX_W-1:0] CFG_PHRED_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR     = 2'd2;

    localparam logic [CFG_W-1:0] PHRED_OFFSET_RST = 7'd33;
    localparam logic [CFG_W-1:0] LOW_THR_RST      = 7'd20;
    localparam logic [CFG_W-1:0] HIGH_THR_RST     = 7'd30;

    // request into the divider
    typedef struct packed {
        logic start;
        logic pct;      // 1: round(10000*num/den) clamped, 0: round(num/den)
    } div_req_t;

    // status back from the divider
    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

endpackage

FILE: hw/rtl/fqgc_divider.sv
// Shared shift-add multiplier and restoring divider with half-up rounding.
module fqgc_divider #(
    parameter int COUNT_BITS = 40
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fqgc_pkg::div_req_t     req,
    input  logic [COUNT_BITS-1:0]  num,
    input  logic [COUNT_BITS-1:0]  den,
    output fqgc_pkg::div_stat_t    stat,
    output logic [COUNT_BITS-1:0]  quot
);

    localparam int DW    = COUNT_BITS + fqgc_pkg::PCT_W;
    localparam int CNT_W = $clog2(DW);

    typedef enum logic [2:0] {D_IDLE, D_CMP, D_MUL, D_DIV, D_RND} dstate_t;

    dstate_t               state_reg;
    logic                  pct_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DW-1:0]         quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] quot_reg;
    logic                  done_reg;
    logic                  sat_reg;

    logic [COUNT_BITS:0]   sub_a;
    logic                  sub_cin;
    logic [COUNT_BITS+1:0] diff;
    logic                  borrow;
    logic [DW-1:0]         add_a;
    logic [DW-1:0]         add_b;
    logic [DW-1:0]         add_out;
    logic [3:0]            mul_bit;
    logic                  div_last;

    // one subtractor serves the clamp test, the divide steps and the rounding test
    always_comb begin
        sub_cin = 1'b0;
        case (state_reg)
            D_CMP: begin
                sub_a   = {1'b0, num};
                sub_cin = 1'b1;
            end
            D_DIV:   sub_a = {rem_reg, quo_reg[DW-1]};
            D_RND:   sub_a = {rem_reg, 1'b0};
            default: sub_a = {1'b0, num};
        endcase
        diff   = {1'b0, sub_a} - {2'b00, den} - {{(COUNT_BITS+1){1'b0}}, sub_cin};
        borrow = diff[COUNT_BITS+1];
    end

    // one adder serves the times-10000 Horner steps and the rounding increment
    always_comb begin
        mul_bit = 4'(fqgc_pkg::PCT_W - 1) - cnt_reg[3:0];
        if (state_reg == D_MUL) begin
            add_a = {quo_reg[DW-2:0], 1'b0};
            add_b = fqgc_pkg::PCT_FULL[mul_bit] ? {{fqgc_pkg::PCT_W{1'b0}}, num} : '0;
        end else begin
            add_a = quo_reg;
            add_b = {{(DW-1){1'b0}}, ~borrow};
        end
        add_out = add_a + add_b;
    end

    assign div_last = pct_reg ? (cnt_reg == CNT_W'(DW - 1))
                              : (cnt_reg == CNT_W'(COUNT_BITS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        pct_reg <= req.pct;
                        sat_reg <= 1'b0;
                        if (req.pct) begin
                            state_reg <= D_CMP;
                        end else begin
                            quo_reg   <= {num, {fqgc_pkg::PCT_W{1'b0}}};
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= D_DIV;
                        end
                    end
                end
                D_CMP: begin
                    if (!borrow) begin
                        // tally above bases: clamp
                        quot_reg  <= COUNT_BITS'(fqgc_pkg::PCT_FULL);
                        sat_reg   <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end else begin
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL: begin
                    quo_reg <= add_out;
                    if (cnt_reg == CNT_W'(fqgc_pkg::PCT_W - 1)) begin
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        state_reg <= D_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                D_DIV: begin
                    quo_reg <= {quo_reg[DW-2:0], ~borrow};
                    rem_reg <= borrow ? sub_a[COUNT_BITS-1:0] : diff[COUNT_BITS-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_last) begin
                        state_reg <= D_RND;
                    end
                end
                D_RND: begin
                    quot_reg  <= add_out[COUNT_BITS-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign quot      = quot_reg;

endmodule

FILE: hw/rtl/fastq_quality_gc_stats_unit.sv
// FASTQ Q20/Q30/GC statistics: byte-stream counters and end-of-file report.
//
// Bytes of the FASTQ text enter one per cycle on the s_ side; the first byte of a
// stream is dropped and lines split at newline. Sequence lines feed the base and
// G/C counters, quality lines the two threshold tallies. The beat marked with
// s_tlast closes the stream: s_tready then drops while one shared multiply/divide
// unit works out the three percentages (start, clamp test, 14 Horner steps,
// COUNT_BITS+14 restoring steps and a rounding step each) and the mean read length
// (COUNT_BITS restoring steps and a rounding step), one bit per cycle. An empty
// stream skips the divider, and a clamped percentage skips the Horner, restoring
// and rounding steps. The report then sits in the output register, all counters
// return to zero and byte input resumes; a further end of file waits only if the
// previous report has not yet been taken.
module fastq_quality_gc_stats_unit #(
    parameter int COUNT_BITS = 40
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_we,
    input  logic [fqgc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fqgc_pkg::CFG_W-1:0]           cfg_wdata,
    // byte stream in
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // data_byte
    input  logic                                 s_tlast,   // end_of_file
    // report out
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // low_quality_pct, high_quality_pct, gc_pct, mean_read_length, total_bases, zero pad
    output logic [fqgc_pkg::M_DATA_W-1:0]        m_tdata,
    // empty_flag, saturated_flag
    output logic [fqgc_pkg::M_USER_W-1:0]        m_tuser
);

    localparam int PW = fqgc_pkg::PCT_W;
    localparam int OW = fqgc_pkg::OUT_W;

    typedef enum logic [1:0] {T_IDLE, T_CHK, T_RUN, T_OUT} tstate_t;
    typedef enum logic [1:0] {JOB_LQ, JOB_HQ, JOB_GC, JOB_MEAN} job_t;

    tstate_t state_reg;
    job_t    job_reg;

    logic [fqgc_pkg::CFG_W-1:0] phred_reg, low_thr_reg, high_thr_reg;

    logic                  first_reg, first_next;
    logic                  open_reg, open_next;
    logic [COUNT_BITS-1:0] line_reg, line_next;
    logic [COUNT_BITS-1:0] lq_cnt_reg, lq_cnt_next;
    logic [COUNT_BITS-1:0] hq_cnt_reg, hq_cnt_next;
    logic [COUNT_BITS-1:0] gc_cnt_reg, gc_cnt_next;
    logic [COUNT_BITS-1:0] base_reg, base_next;

    logic [PW-1:0]         lq_pct_reg, hq_pct_reg, gc_pct_reg;
    logic [COUNT_BITS-1:0] mean_reg;
    logic                  empty_reg, sat_reg;

    logic                  m_valid_reg;
    logic [fqgc_pkg::M_DATA_W-1:0] m_data_reg;
    logic [fqgc_pkg::M_USER_W-1:0] m_user_reg;

    logic                  div_start_reg;
    fqgc_pkg::div_req_t    div_req;
    fqgc_pkg::div_stat_t   div_stat;
    logic [COUNT_BITS-1:0] div_num, div_den, div_quot;

    logic                  in_beat;
    logic [1:0]            phase;
    logic [7:0]            low_lim, high_lim;
    logic [COUNT_BITS-1:0] records;
    logic                  empty_now;
    logic [COUNT_BITS+OW-1:0] mean_wide, base_wide;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == T_IDLE);

    // q >= thr is byte >= offset + thr; bytes of 128 and up never count
    assign low_lim  = {1'b0, phred_reg} + {1'b0, low_thr_reg};
    assign high_lim = {1'b0, phred_reg} + {1'b0, high_thr_reg};
    assign phase    = line_reg[1:0] + 2'd1;

    always_comb begin
        first_next  = first_reg;
        open_next   = open_reg;
        line_next   = line_reg;
        lq_cnt_next = lq_cnt_reg;
        hq_cnt_next = hq_cnt_reg;
        gc_cnt_next = gc_cnt_reg;
        base_next   = base_reg;
        if (!first_reg) begin
            first_next = 1'b1;
        end else if (s_tdata == fqgc_pkg::CHAR_NL) begin
            line_next = line_reg + 1'b1;
            open_next = 1'b0;
        end else begin
            open_next = 1'b1;
            if (phase == 2'd0 && !s_tdata[7]) begin
                if (s_tdata >= low_lim)  lq_cnt_next = lq_cnt_reg + 1'b1;
                if (s_tdata >= high_lim) hq_cnt_next = hq_cnt_reg + 1'b1;
            end else if (phase == 2'd2) begin
                base_next = base_reg + 1'b1;
                if (s_tdata == fqgc_pkg::CHAR_G || s_tdata == fqgc_pkg::CHAR_C) begin
                    gc_cnt_next = gc_cnt_reg + 1'b1;
                end
            end
        end
        // an unterminated last line still counts
        if (s_tlast && open_next) begin
            line_next = line_next + 1'b1;
        end
    end

    assign records   = {2'b00, line_reg[COUNT_BITS-1:2]};
    assign empty_now = (base_reg == '0) || (records == '0);

    always_comb begin
        case (job_reg)
            JOB_LQ:   div_num = lq_cnt_reg;
            JOB_HQ:   div_num = hq_cnt_reg;
            JOB_GC:   div_num = gc_cnt_reg;
            default:  div_num = base_reg;
        endcase
        div_den = (job_reg == JOB_MEAN) ? records : base_reg;
    end

    assign div_req.start = div_start_reg;
    assign div_req.pct   = (job_reg != JOB_MEAN);

    fqgc_divider #(
        .COUNT_BITS(COUNT_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phred_reg    <= fqgc_pkg::PHRED_OFFSET_RST;
            low_thr_reg  <= fqgc_pkg::LOW_THR_RST;
            high_thr_reg <= fqgc_pkg::HIGH_THR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                fqgc_pkg::CFG_PHRED_OFFSET: phred_reg    <= cfg_wdata;
                fqgc_pkg::CFG_LOW_THR:      low_thr_reg  <= cfg_wdata;
                fqgc_pkg::CFG_HIGH_THR:     high_thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign mean_wide = {{OW{1'b0}}, mean_reg};
    assign base_wide = {{OW{1'b0}}, base_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            job_reg       <= JOB_LQ;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            first_reg     <= 1'b0;
            open_reg      <= 1'b0;
            line_reg      <= '0;
            lq_cnt_reg    <= '0;
            hq_cnt_reg    <= '0;
            gc_cnt_reg    <= '0;
            base_reg      <= '0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (in_beat) begin
                        first_reg  <= first_next;
                        open_reg   <= open_next;
                        line_reg   <= line_next;
                        lq_cnt_reg <= lq_cnt_next;
                        hq_cnt_reg <= hq_cnt_next;
                        gc_cnt_reg <= gc_cnt_next;
                        base_reg   <= base_next;
                        if (s_tlast) begin
                            state_reg <= T_CHK;
                        end
                    end
                end
                T_CHK: begin
                    sat_reg   <= 1'b0;
                    empty_reg <= empty_now;
                    if (empty_now) begin
                        lq_pct_reg <= '0;
                        hq_pct_reg <= '0;
                        gc_pct_reg <= '0;
                        mean_reg   <= '0;
                        state_reg  <= T_OUT;
                    end else begin
                        job_reg       <= JOB_LQ;
                        div_start_reg <= 1'b1;
                        state_reg     <= T_RUN;
                    end
                end
                T_RUN: begin
                    if (div_stat.done) begin
                        sat_reg <= sat_reg | div_stat.sat;
                        case (job_reg)
                            JOB_LQ: begin
                                lq_pct_reg    <= div_quot[PW-1:0];
                                job_reg       <= JOB_HQ;
                                div_start_reg <= 1'b1;
                            end
                            JOB_HQ: begin
                                hq_pct_reg    <= div_quot[PW-1:0];
                                job_reg       <= JOB_GC;
                                div_start_reg <= 1'b1;
                            end
                            JOB_GC: begin
                                gc_pct_reg    <= div_quot[PW-1:0];
                                job_reg       <= JOB_MEAN;
                                div_start_reg <= 1'b1;
                            end
                            default: begin
                                mean_reg  <= div_quot;
                                state_reg <= T_OUT;
                            end
                        endcase
                    end
                end
                T_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{(fqgc_pkg::M_DATA_W - fqgc_pkg::M_DATA_BITS){1'b0}},
                                        base_wide[OW-1:0], mean_wide[OW-1:0],
                                        gc_pct_reg, hq_pct_reg, lq_pct_reg};
                        m_user_reg  <= {sat_reg, empty_reg};
                        first_reg   <= 1'b0;
                        open_reg    <= 1'b0;
                        line_reg    <= '0;
                        lq_cnt_reg  <= '0;
                        hq_cnt_reg  <= '0;
                        gc_cnt_reg  <= '0;
                        base_reg    <= '0;
                        state_reg   <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: hw/rtl/fqgc_checker.sv
// Port-level checks on the statistics block, bound to its top level.
module fqgc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fqgc_pkg::M_DATA_W-1:0] m_tdata,
    input logic [fqgc_pkg::M_USER_W-1:0] m_tuser
);

    localparam int PW = fqgc_pkg::PCT_W;

    // the report is worked out after the closing beat, never alongside it
    a_busy_after_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after end-of-file beat");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[fqgc_pkg::LQ_LSB +: PW] <= fqgc_pkg::PCT_FULL &&
                      m_tdata[fqgc_pkg::HQ_LSB +: PW] <= fqgc_pkg::PCT_FULL &&
                      m_tdata[fqgc_pkg::GC_LSB +: PW] <= fqgc_pkg::PCT_FULL))
        else $error("percentage above full scale");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[fqgc_pkg::EMPTY_BIT]) |->
            (m_tdata[fqgc_pkg::TOT_LSB-1:0] == '0 && !m_tuser[fqgc_pkg::SAT_BIT]))
        else $error("empty report carries ratios or saturation");

    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[fqgc_pkg::SAT_BIT]) |->
            (m_tdata[fqgc_pkg::LQ_LSB +: PW] == fqgc_pkg::PCT_FULL ||
             m_tdata[fqgc_pkg::HQ_LSB +: PW] == fqgc_pkg::PCT_FULL ||
             m_tdata[fqgc_pkg::GC_LSB +: PW] == fqgc_pkg::PCT_FULL))
        else $error("saturation flagged without a clamped percentage");

endmodule

bind fastq_quality_gc_stats_unit fqgc_checker u_fqgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/fastq_quality_gc_stats_unit_tb.sv
// Self-checking testbench for the FASTQ Q20/Q30/GC statistics unit.
module fastq_quality_gc_stats_unit_tb;

    localparam int PW = fqgc_pkg::PCT_W;
    localparam int OW = fqgc_pkg::OUT_W;
    localparam int CW = fqgc_pkg::CFG_W;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 300;    // a little over the end-of-file report time
    localparam int RANDOM_BYTES = 1300;
    localparam int PHASE_BYTES  = 160;

    // no register lives here, writes must be dropped
    localparam logic [fqgc_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct {
        logic [PW-1:0] lq_pct;
        logic [PW-1:0] hq_pct;
        logic [PW-1:0] gc_pct;
        logic [OW-1:0] mean_len;
        logic [OW-1:0] total_bases;
        logic          empty;
        logic          sat;
    } stats_report_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [fqgc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CW-1:0]                       cfg_wdata = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata = '0;     // data_byte
    logic                                s_tlast = 1'b0;   // end_of_file
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    // low_quality_pct, high_quality_pct, gc_pct, mean_read_length, total_bases, zero pad
    logic [fqgc_pkg::M_DATA_W-1:0]       m_tdata;
    // empty_flag, saturated_flag
    logic [fqgc_pkg::M_USER_W-1:0]       m_tuser;

    fastq_quality_gc_stats_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // shadow registers and stream counters of the statistics model
    logic [CW-1:0] qual_offset = fqgc_pkg::PHRED_OFFSET_RST;
    logic [CW-1:0] low_floor   = fqgc_pkg::LOW_THR_RST;
    logic [CW-1:0] high_floor  = fqgc_pkg::HIGH_THR_RST;
    logic          head_dropped = 1'b0;
    logic [OW-1:0] line_cnt = '0;
    logic          line_open = 1'b0;
    logic [OW-1:0] lq_cnt = '0;
    logic [OW-1:0] hq_cnt = '0;
    logic [OW-1:0] gc_cnt = '0;
    logic [OW-1:0] base_cnt = '0;

    stats_report_t pending_reports[$];
    logic [7:0]    stream_bytes[$];

    int fail_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int streams_closed = 0;
    int burst_left = 0;
    bit tx_bursty = 1'b1;

    logic [5:0]  rx_tick = '0;
    logic [1:0]  rx_mode = '0;
    logic [15:0] rx_pattern = '0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver back-pressure: stretches of always-ready, a rotating mask or coin flips, chosen anew when rx_tick wraps
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_tick == '0) begin
            rx_mode    <= 2'($urandom_range(0, 2));
            rx_pattern <= 16'($urandom);
        end else begin
            rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
        end
        case (rx_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= rx_pattern[0];
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // round-half-up 10000*num/den with the clamp flag on top; den is nonzero
    function automatic logic [PW:0] scaled_share(input logic [OW-1:0] num,
                                                 input logic [OW-1:0] den);
        logic [63:0] quot;
        if (num > den)
            return {1'b1, fqgc_pkg::PCT_FULL};
        quot = (64'(num) * 64'd20000 + 64'(den)) / (64'(den) * 64'd2);
        return {1'b0, quot[PW-1:0]};
    endfunction

    task automatic account_byte(input logic [7:0] b, input logic eof);
        logic [1:0]    phase;
        int            qual;
        logic [OW-1:0] recs;
        logic [PW:0]   share;
        logic [63:0]   mean;
        stats_report_t r;
        if (!head_dropped) begin
            head_dropped = 1'b1;
        end else if (b == fqgc_pkg::CHAR_NL) begin
            line_cnt++;
            line_open = 1'b0;
        end else begin
            phase = line_cnt[1:0] + 2'd1;
            line_open = 1'b1;
            if (phase == 2'd0 && b < 8'd128) begin
                qual = int'(b) - int'(qual_offset);
                if (qual >= int'(low_floor))
                    lq_cnt++;
                if (qual >= int'(high_floor))
                    hq_cnt++;
            end else if (phase == 2'd2) begin
                base_cnt++;
                if (b == fqgc_pkg::CHAR_G || b == fqgc_pkg::CHAR_C)
                    gc_cnt++;
            end
        end
        if (eof) begin
            if (line_open)
                line_cnt++;
            recs = line_cnt >> 2;
            r.empty = (base_cnt == '0) || (recs == '0);
            r.sat = 1'b0;
            r.lq_pct = '0;
            r.hq_pct = '0;
            r.gc_pct = '0;
            r.mean_len = '0;
            r.total_bases = base_cnt;
            if (!r.empty) begin
                share = scaled_share(lq_cnt, base_cnt);
                r.lq_pct = share[PW-1:0];
                r.sat |= share[PW];
                share = scaled_share(hq_cnt, base_cnt);
                r.hq_pct = share[PW-1:0];
                r.sat |= share[PW];
                share = scaled_share(gc_cnt, base_cnt);
                r.gc_pct = share[PW-1:0];
                r.sat |= share[PW];
                mean = (64'(base_cnt) * 64'd2 + 64'(recs)) / (64'(recs) * 64'd2);
                r.mean_len = mean[OW-1:0];
            end
            pending_reports.push_back(r);
            streams_closed++;
            head_dropped = 1'b0;
            line_cnt = '0;
            line_open = 1'b0;
            lq_cnt = '0;
            hq_cnt = '0;
            gc_cnt = '0;
            base_cnt = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        stats_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("report beat with nothing expected");
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("low_quality_pct", 64'(want.lq_pct),
                            64'(m_tdata[fqgc_pkg::LQ_LSB +: PW]));
                check_field("high_quality_pct", 64'(want.hq_pct),
                            64'(m_tdata[fqgc_pkg::HQ_LSB +: PW]));
                check_field("gc_pct", 64'(want.gc_pct),
                            64'(m_tdata[fqgc_pkg::GC_LSB +: PW]));
                check_field("mean_read_length", 64'(want.mean_len),
                            64'(m_tdata[fqgc_pkg::MEAN_LSB +: OW]));
                check_field("total_bases", 64'(want.total_bases),
                            64'(m_tdata[fqgc_pkg::TOT_LSB +: OW]));
                check_field("empty_flag", 64'(want.empty),
                            64'(m_tuser[fqgc_pkg::EMPTY_BIT]));
                check_field("saturated_flag", 64'(want.sat),
                            64'(m_tuser[fqgc_pkg::SAT_BIT]));
            end
        end
    end

    // one byte beat; bursts of random length with random gaps in between while tx_bursty is set
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = tx_bursty ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
        account_byte(b, eof);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string txt, input bit eof_at_end);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], eof_at_end && (i == txt.len() - 1));
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    // sender goes quiet until every report is back; optional hold-off for the divider
    task automatic settle_block(input bit hold_off);
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_reports.size() != 0);
        if (hold_off)
            repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_registers(input logic [CW-1:0] off, input logic [CW-1:0] lo,
                                   input logic [CW-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= fqgc_pkg::CFG_PHRED_OFFSET;
        cfg_wdata <= off;
        @(posedge aclk);
        qual_offset = off;
        cfg_index <= fqgc_pkg::CFG_LOW_THR;
        cfg_wdata <= lo;
        @(posedge aclk);
        low_floor = lo;
        cfg_index <= fqgc_pkg::CFG_HIGH_THR;
        cfg_wdata <= hi;
        @(posedge aclk);
        high_floor = hi;
        cfg_index <= CFG_SPARE_IDX;
        cfg_wdata <= CW'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic build_stream();
        string      bases;
        int         kind;
        int         nrec;
        int         seq_len;
        int         qual_len;
        int         cut;
        logic [7:0] qb;
        bases = "ACGTNGCacgt";
        stream_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
            nrec = $urandom_range(1, 3);
            for (int r = 0; r < nrec; r++) begin
                stream_bytes.push_back("@");
                repeat ($urandom_range(0, 4))
                    stream_bytes.push_back(8'($urandom_range(8'h30, 8'h7A)));
                stream_bytes.push_back(fqgc_pkg::CHAR_NL);
                seq_len = $urandom_range(0, 10);
                for (int i = 0; i < seq_len; i++) begin
                    if ($urandom_range(0, 15) == 0)
                        stream_bytes.push_back(8'($urandom));
                    else
                        stream_bytes.push_back(bases[$urandom_range(0, bases.len() - 1)]);
                end
                stream_bytes.push_back(fqgc_pkg::CHAR_NL);
                stream_bytes.push_back("+");
                stream_bytes.push_back(fqgc_pkg::CHAR_NL);
                // a quality line longer than its read drives the tallies past the base count
                qual_len = seq_len + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
                for (int i = 0; i < qual_len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        qb = 8'($urandom);
                    else
                        qb = 8'(qual_offset) + 8'($urandom_range(0, 45));
                    stream_bytes.push_back(qb);
                end
                if (r < nrec - 1 || $urandom_range(0, 2) != 0)
                    stream_bytes.push_back(fqgc_pkg::CHAR_NL);
            end
            // broken tail: the file may stop somewhere inside a record
            if (kind == 7) begin
                cut = $urandom_range(1, stream_bytes.size());
                while (stream_bytes.size() > cut)
                    void'(stream_bytes.pop_back());
            end
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 30))
                stream_bytes.push_back(($urandom_range(0, 4) == 0) ? fqgc_pkg::CHAR_NL
                                                                    : 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3))
                stream_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic test_eof_on_first_byte();
        send_byte(8'hFF, 1'b1);
    endtask

    // one record, last quality line unterminated: above both, exactly low, negative,
    // high byte, exactly high
    task automatic test_single_record();
        send_text("@\nGCAT\n+\nI5", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("?", 1'b1);
    endtask

    // offset 0, thresholds at the extremes; two quality bytes against one base clamps
    task automatic test_saturation_extremes();
        settle_block(1'b1);
        write_registers(7'd0, 7'd94, 7'd0);
        send_text("x\nG\n\nab\n", 1'b1);
    endtask

    task automatic test_random_streams();
        int            phase;
        int            phase_bytes;
        logic [CW-1:0] off;
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
        phase = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            settle_block(1'b1);
            case (phase)
                0: begin off = 7'd127; lo = 7'd0;   hi = 7'd127; end
                1: begin off = 7'd0;   lo = 7'd127; hi = 7'd94;  end
                2: begin
                    off = fqgc_pkg::PHRED_OFFSET_RST;
                    lo  = fqgc_pkg::LOW_THR_RST;
                    hi  = fqgc_pkg::HIGH_THR_RST;
                end
                default: begin
                    off = ($urandom_range(0, 3) == 0) ? 7'd64 : 7'($urandom_range(0, 127));
                    lo  = ($urandom_range(0, 3) == 0) ? 7'd0  : 7'($urandom_range(0, 127));
                    hi  = ($urandom_range(0, 3) == 0) ? 7'd94 : 7'($urandom_range(0, 127));
                end
            endcase
            write_registers(off, lo, hi);
            tx_bursty = (phase % 3 != 2);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                if ($urandom_range(0, 7) == 0)
                    settle_block(1'b0);
                build_stream();
                send_stream();
                phase_bytes += stream_bytes.size();
            end
            phase++;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_eof_on_first_byte();
        test_single_record();
        test_saturation_extremes();
        test_random_streams();
        settle_block(1'b1);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/fqgc_pkg.sv
hw/rtl/fqgc_divider.sv
hw/rtl/fastq_quality_gc_stats_unit.sv
hw/rtl/fqgc_checker.sv
tb/sv/fastq_quality_gc_stats_unit_tb.sv
